>>> rtl/imu_frame_checksum_deframer_macros.svh
// ----------------------------------------------------------------------------
// imu_frame_checksum_deframer_macros.svh
// Assertion macros used by the deframer's frame controller.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_CHECKSUM_DEFRAMER_MACROS_SVH
`define IMU_FRAME_CHECKSUM_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IFCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define IFCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ifcd_pkg.sv
// ----------------------------------------------------------------------------
// ifcd_pkg
// Types and constants of the header/length/checksum frame deframer.
// ----------------------------------------------------------------------------
package ifcd_pkg;

   localparam int PAYLOAD_MAX_DEFAULT = 16;

   localparam logic [7:0] HDR_BYTE = 8'h55;
   localparam logic [7:0] HDR_SUM  = 8'hAA;

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_ID,
      PH_LEN,
      PH_DATA,
      PH_CHECK,
      PH_EMIT_RD,
      PH_EMIT_WR
   } phase_type;

   typedef enum logic [1:0] {
      ST_GOOD     = 2'd0,
      ST_BAD_SUM  = 2'd1,
      ST_TOO_LONG = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]         frame_id;
      logic [7:0]         payload_length;
      logic [4:0]         word_index;
      logic signed [15:0] word_value;
      status_type         status;
      logic               last;
   } rsp_type;

endpackage

>>> rtl/imu_frame_checksum_deframer.sv
// ----------------------------------------------------------------------------
// imu_frame_checksum_deframer
// Serial frame deframer with header, id, length, payload and sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one received byte per request. The block hunts
//   for the header 0x55 0x55, then takes id, length, payload and checksum.
//   The rsp channel carries one result per 16-bit payload word of a good
//   frame (little-endian, signed, last word marked), or a single error
//   result for a checksum mismatch or a length above PAYLOAD_MAX.
//   Header, id and payload bytes are taken one per cycle. An over-long
//   length or a bad checksum loads its result in the cycle the byte is
//   taken; rsp_valid rises in the next cycle.
//   A good checksum starts the emission: each word is read from the
//   payload store (one read port, registered read) in PH_EMIT_RD and is
//   then loaded into the output register in PH_EMIT_WR; req_stall is high
//   for the whole emission.
//   rsp_stall holds the output register; emission waits and, for the length
//   and checksum bytes, req_stall rises until the register is free.
//   Synchronous reset returns to hunting and empties the output register;
//   the payload store needs no clearing.
// ----------------------------------------------------------------------------
module imu_frame_checksum_deframer #(
   parameter int PAYLOAD_MAX = ifcd_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_id,
   output logic [7:0]         rsp_payload_length,
   output logic [4:0]         rsp_word_index,
   output logic signed [15:0] rsp_word_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);
   import ifcd_pkg::*;

   localparam int WORDS = (PAYLOAD_MAX + 1) / 2;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

   logic             out_free;
   logic             res_load;
   rsp_type          res;
   logic             wr_en;
   logic [CNT_W-1:0] wr_idx;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [7:0]       rd_lo;
   logic [7:0]       rd_hi;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   ifcd_frame_ctrl #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_lo       (rd_lo),
      .rd_hi       (rd_hi)
   );

   ifcd_payload_ram #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_lo   (rd_lo),
      .rd_hi   (rd_hi)
   );

   // Output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload while stalled
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_id       = rsp_data_ff.frame_id;
   assign rsp_payload_length = rsp_data_ff.payload_length;
   assign rsp_word_index     = rsp_data_ff.word_index;
   assign rsp_word_value     = rsp_data_ff.word_value;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_last           = rsp_data_ff.last;

endmodule

>>> rtl/ifcd_payload_ram.sv
// ----------------------------------------------------------------------------
// ifcd_payload_ram
// Payload byte store in two byte lanes (even and odd bytes) sharing one word
// address, registered read of a whole 16-bit word.
// ----------------------------------------------------------------------------
module ifcd_payload_ram #(
   parameter int PAYLOAD_MAX = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(PAYLOAD_MAX + 1) - 1:0] wr_idx,
   input  logic [7:0]                           wr_data,
   input  logic                                 rd_en,
   input  logic [(((PAYLOAD_MAX + 1) / 2) > 1 ?
                  $clog2((PAYLOAD_MAX + 1) / 2) : 1) - 1:0] rd_addr,
   output logic [7:0]                           rd_lo,
   output logic [7:0]                           rd_hi
);
   import ifcd_pkg::*;

   localparam int WORDS = (PAYLOAD_MAX + 1) / 2;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [7:0]    lane_lo [WORDS];
   logic [7:0]    lane_hi [WORDS];
   logic [AW-1:0] wr_addr;
   logic [7:0]    rd_lo_ff;
   logic [7:0]    rd_hi_ff;

   assign wr_addr = AW'(wr_idx >> 1);

   // Write the byte into the lane picked by its low index bit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_idx[0]) begin
            lane_hi[wr_addr] <= wr_data;
         end else begin
            lane_lo[wr_addr] <= wr_data;
         end
      end
   end

   // Read both lanes of one word, hold until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_lo_ff <= lane_lo[rd_addr];
         rd_hi_ff <= lane_hi[rd_addr];
      end
   end

   assign rd_lo = rd_lo_ff;
   assign rd_hi = rd_hi_ff;

endmodule

>>> rtl/ifcd_frame_ctrl.sv
// ----------------------------------------------------------------------------
// ifcd_frame_ctrl
// Byte parser and word emitter: hunts the header, keeps id, length and the
// running checksum, writes payload bytes to the store and reads them back
// as words once the checksum byte matches.
// ----------------------------------------------------------------------------
`include "imu_frame_checksum_deframer_macros.svh"

module ifcd_frame_ctrl #(
   parameter int PAYLOAD_MAX = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_rx_byte,
   input  logic                                 out_free,
   output logic                                 res_load,
   output ifcd_pkg::rsp_type                    res,
   output logic                                 wr_en,
   output logic [$clog2(PAYLOAD_MAX + 1) - 1:0] wr_idx,
   output logic [7:0]                           wr_data,
   output logic                                 rd_en,
   output logic [(((PAYLOAD_MAX + 1) / 2) > 1 ?
                  $clog2((PAYLOAD_MAX + 1) / 2) : 1) - 1:0] rd_addr,
   input  logic [7:0]                           rd_lo,
   input  logic [7:0]                           rd_hi
);
   import ifcd_pkg::*;

   localparam int WORDS = (PAYLOAD_MAX + 1) / 2;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
   localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_MAX);

   phase_type      state_ff, state_in;
   logic [7:0]     held_id_ff, held_id_in;
   logic [7:0]     held_length_ff, held_length_in;
   logic [7:0]     running_sum_ff, running_sum_in;
   logic [CNT_W-1:0] bytes_taken_ff, bytes_taken_in;
   logic [AW-1:0]  word_ff, word_in;
   logic           accept;
   logic           hi_keep;
   logic           last_word;

   // Stall while emitting, or when a length or checksum byte finds the slot busy
   assign req_stall = (state_ff == PH_EMIT_RD) || (state_ff == PH_EMIT_WR) ||
                      (((state_ff == PH_LEN) || (state_ff == PH_CHECK)) && !out_free);
   assign accept    = req_valid && !req_stall;

   // Word position tests against the received length
   assign hi_keep   = 9'({word_ff, 1'b1}) < {1'b0, held_length_ff};
   assign last_word = (9'({word_ff, 1'b0}) + 9'd2) >= {1'b0, held_length_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_HUNT1;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      held_id_ff     <= held_id_in;
      held_length_ff <= held_length_in;
      running_sum_ff <= running_sum_in;
      bytes_taken_ff <= bytes_taken_in;
      word_ff        <= word_in;
   end

   // Next state, store access and result
   always_comb begin
      state_in           = state_ff;
      held_id_in         = held_id_ff;
      held_length_in     = held_length_ff;
      running_sum_in     = running_sum_ff;
      bytes_taken_in     = bytes_taken_ff;
      word_in            = word_ff;
      res_load           = 1'b0;
      res.frame_id       = held_id_ff;
      res.payload_length = held_length_ff;
      res.word_index     = 5'(word_ff);
      res.word_value     = '0;
      res.status         = ST_GOOD;
      res.last           = 1'b1;
      wr_en              = 1'b0;
      wr_idx             = bytes_taken_ff;
      wr_data            = req_rx_byte;
      rd_en              = 1'b0;
      rd_addr            = word_ff;

      case (state_ff)
         PH_HUNT1: begin
            if (accept && (req_rx_byte == HDR_BYTE)) begin
               state_in = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            if (accept) begin
               state_in = (req_rx_byte == HDR_BYTE) ? PH_ID : PH_HUNT1;
            end
         end
         PH_ID: begin
            if (accept) begin
               held_id_in     = req_rx_byte;
               running_sum_in = HDR_SUM + req_rx_byte;
               state_in       = PH_LEN;
            end
         end
         PH_LEN: begin
            if (accept) begin
               held_length_in = req_rx_byte;
               running_sum_in = running_sum_ff + req_rx_byte;
               bytes_taken_in = '0;
               if (req_rx_byte > LEN_LIMIT) begin
                  // Flag an over-long frame at once and resume hunting
                  res_load           = 1'b1;
                  res.payload_length = req_rx_byte;
                  res.word_index     = '0;
                  res.status         = ST_TOO_LONG;
                  state_in           = PH_HUNT1;
               end else begin
                  state_in = (req_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (accept) begin
               wr_en          = 1'b1;
               running_sum_in = running_sum_ff + req_rx_byte;
               bytes_taken_in = bytes_taken_ff + 1'b1;
               if ((8'(bytes_taken_ff) + 8'd1) >= held_length_ff) begin
                  state_in = PH_CHECK;
               end
            end
         end
         PH_CHECK: begin
            if (accept) begin
               word_in = '0;
               if (req_rx_byte != running_sum_ff) begin
                  res_load       = 1'b1;
                  res.word_index = '0;
                  res.status     = ST_BAD_SUM;
                  state_in       = PH_HUNT1;
               end else if (held_length_ff == 8'd0) begin
                  state_in = PH_HUNT1;
               end else begin
                  state_in = PH_EMIT_RD;
               end
            end
         end
         PH_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = PH_EMIT_WR;
         end
         PH_EMIT_WR: begin
            // Hand the word over once the output slot is free
            if (out_free) begin
               res_load       = 1'b1;
               res.word_value = {(hi_keep ? rd_hi : 8'd0), rd_lo};
               res.last       = last_word;
               if (last_word) begin
                  state_in = PH_HUNT1;
               end else begin
                  word_in  = word_ff + 1'b1;
                  state_in = PH_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = PH_HUNT1;
         end
      endcase
   end

   `IFCD_ASSERT_IMP(a_load_into_free_slot, clock, reset, res_load, out_free,
      "result loaded while the output slot is still occupied")
   `IFCD_ASSERT_IMP(a_load_states, clock, reset, res_load,
      (state_ff == PH_LEN) || (state_ff == PH_CHECK) || (state_ff == PH_EMIT_WR),
      "result produced in a state that yields none")
   `IFCD_ASSERT_IMP(a_count_in_range, clock, reset, state_ff == PH_DATA,
      32'(bytes_taken_ff) < PAYLOAD_MAX, "payload byte count ran past the store")
   `IFCD_ASSERT_NXT(a_read_then_emit, clock, reset, state_ff == PH_EMIT_RD,
      state_ff == PH_EMIT_WR, "store read not followed by word emission")
   `IFCD_ASSERT_IMP(a_emit_after_read, clock, reset, state_ff == PH_EMIT_WR,
      ($past(state_ff) == PH_EMIT_RD) || ($past(state_ff) == PH_EMIT_WR),
      "word emitted without a preceding store read")

endmodule
